[design/rfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants and types for the register file ALU with condition flags.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int REG_COUNT  = 10;
  localparam int COND_INDEX = REG_COUNT - 1;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int DATA_W     = 32;
  localparam int SIGN_BIT   = 31;
  localparam int IDX_W      = 4;
  localparam int IDX_EXT_W  = 6;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_SHL  = 4'd4;
  localparam logic [3:0] OP_SHR  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_AND  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_COPY = 4'd10;

  localparam logic [1:0] CC_ZERO     = 2'd0;
  localparam logic [1:0] CC_NEGATIVE = 2'd1;
  localparam logic [1:0] CC_POSITIVE = 2'd2;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // True when a register index names an entry of the file.
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = {{(IDX_EXT_W-IDX_W){1'b0}}, idx};
    return ext < IDX_EXT_W'(REG_COUNT);
  endfunction

  // Memory address of a register index.
  function automatic logic [REG_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = {{(IDX_EXT_W-IDX_W){1'b0}}, idx};
    return ext[REG_AW-1:0];
  endfunction

endpackage

[design/rfa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rfa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_div
  import rfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r, quo_r, dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   shifted, trial;
  logic              ge;

  // A zero divisor makes every trial succeed, so the quotient is all ones.
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/register_file_alu_with_flags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_file_alu_with_flags
// Processes one item at a time: a new beat is taken only once the previous
// result has entered the output register, and a divide holds the sequencer
// until the bit-serial divider is done. The file sits in one simple dual-port
// RAM. Synchronous reset idles the sequencer and makes every register of the
// file read as zero.
// ----------------------------------------------------------------------------
module register_file_alu_with_flags
  import rfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [IDX_W-1:0]  in_dest_reg,
  input  logic [IDX_W-1:0]  in_src_reg,
  input  logic [DATA_W-1:0] in_immediate,
  input  logic [3:0]        in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_result_value,
  output logic [1:0]        out_condition,
  output logic              out_bad_operation
);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDA  = 8'b0000_0010,
    S_RDB  = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_WC   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Fields of the beat in flight.
  logic              kind_r;
  logic [IDX_W-1:0]  dst_r, src_r;
  logic [DATA_W-1:0] imm_r;
  logic [3:0]        op_r;

  // Operands and result.
  logic [DATA_W-1:0] a_r, b_r, res_r;
  logic [1:0]        cc_r;

  // Valid bit per entry: an entry never written since reset reads as zero.
  logic [REG_COUNT-1:0] vld_r;
  // Low bits of the condition register, kept beside the RAM for the output.
  logic [1:0]           cond_r;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_val_r;
  logic [1:0]        out_cond_r;
  logic              out_bad_r;

  // RAM ports.
  logic              ram_we;
  logic [REG_AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Divider.
  logic              div_start;
  logic [DATA_W-1:0] div_quo;
  div_stat_t         div_stat;

  // Decode of the held beat.
  logic              dst_ok, src_ok, dst_is_cond;
  logic              bad, flags;
  logic [DATA_W-1:0] alu_res, prod, dst_val;
  logic [1:0]        cc_nxt;
  logic              load_out;

  assign dst_ok      = idx_ok(dst_r);
  assign src_ok      = idx_ok(src_r);
  assign dst_is_cond = dst_ok && (to_addr(dst_r) == REG_AW'(COND_INDEX));

  always_comb begin
    bad   = 1'b0;
    flags = 1'b1;
    case (op_r) inside
      [OP_ADD:OP_NOT]: ;
      OP_COPY: flags = 1'b0;
      default: begin
        bad   = 1'b1;
        flags = 1'b0;
      end
    endcase
  end

  assign prod = a_r * b_r;

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = a_r + b_r;
      OP_SUB:  alu_res = a_r - b_r;
      OP_MUL:  alu_res = prod;
      OP_SHL:  alu_res = (b_r >= DATA_W'(DATA_W)) ? '0 : (a_r << b_r[4:0]);
      OP_SHR:  alu_res = (b_r >= DATA_W'(DATA_W)) ? '0 : (a_r >> b_r[4:0]);
      OP_OR:   alu_res = a_r | b_r;
      OP_XOR:  alu_res = a_r ^ b_r;
      OP_AND:  alu_res = a_r & b_r;
      OP_NOT:  alu_res = ~a_r;
      OP_COPY: alu_res = b_r;
      default: alu_res = a_r;
    endcase
  end

  // The value the destination holds once written; a register outside the
  // file reads back as zero.
  assign dst_val = dst_ok ? res_r : '0;

  always_comb begin
    if (dst_val == '0) begin
      cc_nxt = CC_ZERO;
    end else if (dst_val[SIGN_BIT]) begin
      cc_nxt = CC_NEGATIVE;
    end else begin
      cc_nxt = CC_POSITIVE;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // The destination is read while the beat is accepted, the source in the next
  // state; the registered read data arrives in the following state.
  assign ram_raddr = (state_r == S_IDLE) ? to_addr(in_dest_reg) : to_addr(src_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = to_addr(dst_r);
    ram_wdata = res_r;
    if (state_r == S_WB) begin
      ram_we = !bad && dst_ok;
    end else if (state_r == S_WC) begin
      ram_we    = 1'b1;
      ram_waddr = REG_AW'(COND_INDEX);
      ram_wdata = {{(DATA_W-2){1'b0}}, cc_r};
    end
  end

  assign div_start = (state_r == S_EXEC) && (op_r == OP_DIV);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = (op_r == OP_DIV) ? S_DIV : S_WB;
      S_DIV:  if (div_stat.done) state_nxt = S_WB;
      S_WB:   state_nxt = flags ? S_WC : S_DONE;
      S_WC:   state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      cond_r      <= CC_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
        if (ram_waddr == REG_AW'(COND_INDEX)) begin
          cond_r <= ram_wdata[1:0];
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      dst_r  <= in_dest_reg;
      src_r  <= in_src_reg;
      imm_r  <= in_immediate;
      op_r   <= in_operation;
    end
    if (state_r == S_RDA) begin
      a_r <= (dst_ok && vld_r[to_addr(dst_r)]) ? ram_rdata : '0;
    end
    if (state_r == S_RDB) begin
      if (kind_r) begin
        b_r <= (src_ok && vld_r[to_addr(src_r)]) ? ram_rdata : '0;
      end else begin
        b_r <= imm_r;
      end
    end
    if (state_r == S_EXEC) begin
      res_r <= alu_res;
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      res_r <= div_quo;
    end
    if (state_r == S_WB) begin
      cc_r <= cc_nxt;
    end
    if (load_out) begin
      // An unknown operation shows the untouched destination; a flag write
      // to the condition register shows the code itself.
      if (bad) begin
        out_val_r <= a_r;
      end else if (flags && dst_is_cond) begin
        out_val_r <= {{(DATA_W-2){1'b0}}, cc_r};
      end else begin
        out_val_r <= dst_val;
      end
      out_cond_r <= cond_r;
      out_bad_r  <= bad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_val_r;
  assign out_condition     = out_cond_r;
  assign out_bad_operation = out_bad_r;

  rfa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

endmodule

[design/rfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks of the register file ALU, bound to the top level.
// ----------------------------------------------------------------------------
module rfa_checker
  import rfa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_result_value
);

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Beats accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken again straight after a beat");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without an accepted input");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two beats outstanding");

endmodule

bind register_file_alu_with_flags rfa_checker u_rfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value)
);

[bench/tb_register_file_alu_with_flags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_file_alu_with_flags
// Self-checking bench for the register file ALU with condition flags. A
// shadow copy of the register file predicts every result beat. The bench
// runs a short directed list and then about 1600 random operations over
// three phases of sender and receiver idling. The last phase includes a long
// receiver hold-off while the sender keeps offering beats.
// ----------------------------------------------------------------------------
module tb_register_file_alu_with_flags;
  import rfa_pkg::*;

  // The codes from here to the top of the four-bit field are not operations.
  localparam logic [3:0] OP_BAD_FIRST = 4'd11;
  localparam logic [3:0] OP_BAD_LAST  = 4'd15;

  // A few register indexes for the directed beats.
  localparam logic [IDX_W-1:0] RA       = 4'd0;
  localparam logic [IDX_W-1:0] RB       = 4'd1;
  localparam logic [IDX_W-1:0] RC       = 4'd2;
  localparam logic [IDX_W-1:0] RD       = 4'd3;
  localparam logic [IDX_W-1:0] RE       = 4'd4;
  localparam logic [IDX_W-1:0] RF       = 4'd5;
  localparam logic [IDX_W-1:0] R_COND   = IDX_W'(COND_INDEX);
  localparam logic [IDX_W-1:0] IDX_OUT  = IDX_W'(REG_COUNT);
  localparam logic [IDX_W-1:0] IDX_TOP  = '1;

  localparam int ITEMS_PER_PHASE = 534;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 60;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  dest_reg;
    logic [IDX_W-1:0]  src_reg;
    logic [DATA_W-1:0] immediate;
    logic [3:0]        operation;
  } alu_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic [1:0]        condition;
    logic              bad_operation;
  } alu_result_t;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic              in_kind           = 1'b0;
  logic [IDX_W-1:0]  in_dest_reg       = '0;
  logic [IDX_W-1:0]  in_src_reg        = '0;
  logic [DATA_W-1:0] in_immediate      = '0;
  logic [3:0]        in_operation      = OP_ADD;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic [1:0]        out_condition;
  logic              out_bad_operation;

  // Operations waiting to be driven, and results waiting to come back.
  alu_op_t           queued_ops[$];
  alu_result_t       predicted_results[$];

  // Shadow of the block's register file, updated at each accepted beat.
  logic [DATA_W-1:0] shadow_regs[REG_COUNT];

  int                snd_idle_pct = 0;
  int                rcv_idle_pct = 0;
  logic              hold_req     = 1'b0;
  logic              hold_done    = 1'b0;
  int                hold_left    = 0;
  logic              in_beat_seen = 1'b0;
  int                error_count  = 0;
  int                cycle_count  = 0;
  alu_op_t           next_op;
  alu_result_t       got, want;

  register_file_alu_with_flags dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_dest_reg       (in_dest_reg),
    .in_src_reg        (in_src_reg),
    .in_immediate      (in_immediate),
    .in_operation      (in_operation),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_condition     (out_condition),
    .out_bad_operation (out_bad_operation)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Indexes from the register count upwards behave as a register that always
  // reads zero and swallows writes.
  function automatic logic [DATA_W-1:0] shadow_read(input logic [IDX_W-1:0] idx);
    if (idx < REG_COUNT) begin
      return shadow_regs[idx];
    end
    return '0;
  endfunction

  // Applies one operation to the shadow file and returns the beat that the
  // block should send back for it.
  function automatic alu_result_t apply_alu_op(input alu_op_t op);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] v;
    logic [1:0]        cc;
    logic              bad;
    logic              set_cc;
    alu_result_t       res;
    a      = shadow_read(op.dest_reg);
    b      = op.kind ? shadow_read(op.src_reg) : op.immediate;
    r      = '0;
    bad    = 1'b0;
    set_cc = 1'b1;
    case (op.operation)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      // Division by zero gives all ones rather than trapping.
      OP_DIV:  r = (b == '0) ? '1 : a / b;
      // Shifts of a whole word or more clear the result.
      OP_SHL:  r = (b >= DATA_W) ? '0 : a << b;
      OP_SHR:  r = (b >= DATA_W) ? '0 : a >> b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_AND:  r = a & b;
      OP_NOT:  r = ~a;
      OP_COPY: begin
        r      = b;
        set_cc = 1'b0;
      end
      default: begin
        bad    = 1'b1;
        set_cc = 1'b0;
      end
    endcase
    if (!bad) begin
      if (op.dest_reg < REG_COUNT) begin
        shadow_regs[op.dest_reg] = r;
      end
      // The condition code is taken from the stored value, so a write to an
      // out-of-range destination records zero.
      if (set_cc) begin
        v = shadow_read(op.dest_reg);
        if (v == '0) begin
          cc = CC_ZERO;
        end else if (v[SIGN_BIT]) begin
          cc = CC_NEGATIVE;
        end else begin
          cc = CC_POSITIVE;
        end
        shadow_regs[COND_INDEX] = DATA_W'(cc);
      end
    end
    res.result_value  = shadow_read(op.dest_reg);
    res.condition     = shadow_regs[COND_INDEX][1:0];
    res.bad_operation = bad;
    return res;
  endfunction

  task automatic queue_op(input logic kind, input logic [IDX_W-1:0] dest,
                          input logic [IDX_W-1:0] src, input logic [DATA_W-1:0] imm,
                          input logic [3:0] opc);
    queued_ops.push_back('{kind, dest, src, imm, opc});
  endtask

  function automatic logic [IDX_W-1:0] random_index();
    // Mostly real registers; now and then one of the constant-zero indexes.
    if ($urandom_range(99) < 12) begin
      return IDX_W'($urandom_range(IDX_TOP, IDX_OUT));
    end
    return IDX_W'($urandom_range(R_COND, RA));
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    int      roll;
    op.kind     = 1'($urandom_range(1));
    op.dest_reg = random_index();
    op.src_reg  = random_index();
    case ($urandom_range(3))
      0:       op.immediate = $urandom();
      1:       op.immediate = DATA_W'($urandom_range(40));
      2: begin
        case ($urandom_range(4))
          0:       op.immediate = '0;
          1:       op.immediate = '1;
          2:       op.immediate = 32'h8000_0000;
          3:       op.immediate = 32'h7FFF_FFFF;
          default: op.immediate = 32'h0000_0001;
        endcase
      end
      default: op.immediate = $urandom() >> $urandom_range(31);
    endcase
    // Copies keep seeding the file with fresh values, so that the arithmetic
    // does not settle on zero.
    roll = $urandom_range(99);
    if (roll < 6) begin
      op.operation = 4'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
    end else if (roll < 22) begin
      op.operation = OP_COPY;
    end else begin
      op.operation = 4'($urandom_range(OP_NOT, OP_ADD));
    end
    return op;
  endfunction

  // Sender: a new beat is offered only once the previous one has been taken,
  // so valid and the payload stay put while the block stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_beat_seen) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_op = queued_ops.pop_front();
          in_kind      <= next_op.kind;
          in_dest_reg  <= next_op.dest_reg;
          in_src_reg   <= next_op.src_reg;
          in_immediate <= next_op.immediate;
          in_operation <= next_op.operation;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, with a single long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: predicts on every input beat and checks every result beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat_seen <= 1'b0;
    end else begin
      in_beat_seen <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_alu_op(
          '{in_kind, in_dest_reg, in_src_reg, in_immediate, in_operation}));
      end
      if (out_valid && out_ready) begin
        got = '{out_result_value, out_condition, out_bad_operation};
        if (predicted_results.size() == 0) begin
          $error("unexpected result beat: result_value %h condition %0d bad_operation %0b",
                 got.result_value, got.condition, got.bad_operation);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.result_value !== want.result_value) begin
            $error("result_value: expected %h, actual %h",
                   want.result_value, got.result_value);
            error_count++;
          end
          if (got.condition !== want.condition) begin
            $error("condition: expected %0d, actual %0d", want.condition, got.condition);
            error_count++;
          end
          if (got.bad_operation !== want.bad_operation) begin
            $error("bad_operation: expected %0b, actual %0b",
                   want.bad_operation, got.bad_operation);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int snd_pct[3];
    int rcv_pct[3];
    snd_pct = '{34, 72, 0};
    rcv_pct = '{72, 34, 0};
    for (int i = 0; i < REG_COUNT; i++) begin
      shadow_regs[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = snd_pct[phase];
      rcv_idle_pct = rcv_pct[phase];

      if (phase == 0) begin
        // Arithmetic round the word boundaries.
        queue_op(1'b0, RA, RA, 32'hFFFF_FFFF, OP_COPY);
        queue_op(1'b0, RB, RA, 32'h7FFF_FFFF, OP_COPY);
        queue_op(1'b1, RA, RB, 32'h0, OP_ADD);
        queue_op(1'b0, RC, RA, 32'h1, OP_SUB);
        queue_op(1'b0, RB, RA, 32'h2, OP_MUL);
        // Division by zero, then a register divided by itself.
        queue_op(1'b0, RA, RA, 32'h0, OP_DIV);
        queue_op(1'b1, RB, RB, 32'h0, OP_DIV);
        // Shifts at the edge of the word and beyond it.
        queue_op(1'b0, RC, RA, 32'd32, OP_SHL);
        queue_op(1'b0, RA, RA, 32'd31, OP_SHL);
        queue_op(1'b0, RA, RA, 32'd31, OP_SHR);
        queue_op(1'b0, RB, RA, 32'hFFFF_FFFF, OP_SHR);
        // Logic operations, each of which must now write back.
        queue_op(1'b0, RD, RA, 32'h8000_0000, OP_OR);
        queue_op(1'b0, RD, RA, 32'hFFFF_FFFF, OP_XOR);
        queue_op(1'b0, RD, RA, 32'h0, OP_AND);
        queue_op(1'b0, RE, RA, 32'h0, OP_NOT);
        // Unknown operation codes leave everything alone.
        queue_op(1'b1, RE, IDX_TOP, 32'h1234_5678, OP_BAD_FIRST);
        queue_op(1'b0, RE, RA, 32'h0, OP_BAD_LAST);
        // Out-of-range indexes read as zero and drop writes.
        queue_op(1'b0, IDX_TOP, RA, 32'h5, OP_ADD);
        queue_op(1'b1, RF, IDX_OUT, 32'h0, OP_COPY);
        queue_op(1'b1, IDX_OUT, RE, 32'h0, OP_COPY);
        // The condition register as destination and as source.
        queue_op(1'b0, R_COND, RA, 32'h10, OP_ADD);
        queue_op(1'b0, R_COND, RA, 32'hFFFF_FFFF, OP_COPY);
        queue_op(1'b0, R_COND, RA, 32'h0, OP_NOT);
        queue_op(1'b1, RA, R_COND, 32'h0, OP_SUB);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queued_ops.push_back(random_op());
      end

      // With the sender never idling, a long receiver stall backs the block up.
      if (phase == 2) begin
        hold_req = 1'b1;
      end

      // Sample just after the edge, once the sender and monitor have settled.
      do begin
        @(posedge clk);
        #1;
      end while (queued_ops.size() != 0 || in_valid || predicted_results.size() != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[register_file_alu_with_flags.f]
design/rfa_pkg.sv
design/rfa_ram.sv
design/rfa_div.sv
design/register_file_alu_with_flags.sv
design/rfa_checker.sv
bench/tb_register_file_alu_with_flags.sv
